// ----- design/mbps_pkg.sv -----
// Package for the masked byte pattern scanner: register indexes, field widths
// and the result type shared by the output buffer and the top level.
// No dependencies.
`default_nettype none

package mbps_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LenRegW   = 5;
  localparam int unsigned MaskRegW  = 16;
  localparam int unsigned IndexW    = 32;
  localparam int unsigned PatBytes  = 16;

  localparam logic [CfgIdxW-1:0] RegPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMask    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLength  = 2'd3;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
  } result_t;

endpackage

`default_nettype wire

// ----- design/masked_byte_pattern_scanner.sv -----
// Masked byte pattern scanner, top level.
// Depends on mbps_pkg, mbps_cell and mbps_out_buf.
//
// Usage: bytes of a memory region enter on the input channel (in_valid_i,
// in_ready_o, data_byte_i, region_end_i), one transaction per byte, with
// region_end_i set on the final byte of the region. The block compares the
// window of the latest bytes against a stored pattern of up to
// MAX_PATTERN_BYTES bytes, in which bytes whose mask bit is clear are
// wildcards. The first match in a region gives one result transaction with
// found_o set and match_index_o holding the offset of the match start. If the
// region ends without a match, the final byte gives one result with found_o
// clear and a zero index. The window, byte count and reported flag then clear
// for the next region.
// Throughput is one byte per cycle while in_ready_o is high: the window is a
// chain of cells that shift by one place per accepted byte, and every cell
// compares its byte in the same cycle. A result is registered in the output
// register, or in the skid register while the output is held, so input keeps
// flowing while one result waits; in_ready_o drops only while both hold a
// result, that is when the receiver has stalled.
// Reset clears the window, the count and both buffer entries, and loads the
// register reset values: zero pattern, full mask and a length of 16.
// Configuration writes are taken in any cycle and should be made only while
// the block is idle; they act from the next byte on.
`default_nettype none

module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Byte input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                region_end_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     found_o,
  output logic [IndexW-1:0]        match_index_o
);

  // Configuration registers.
  logic [CfgDataW-1:0] pat_low_q;
  logic [CfgDataW-1:0] pat_high_q;
  logic [MaskRegW-1:0] mask_q;
  logic [LenRegW-1:0]  len_q;

  // Region state.
  logic [IndexW-1:0] count_q, count_d;
  logic              reported_q, reported_d;

  logic              accept;
  logic              space;
  logic [LenRegW-1:0] len_used;
  logic [IndexW-1:0] count_nxt;
  logic              len_reached;
  logic              window_hit;
  logic              new_found;
  logic              new_miss;
  result_t           res;
  result_t           res_out;

  logic [PatBytes-1:0][7:0]          pat_all;
  logic [MAX_PATTERN_BYTES-1:0][7:0] cell_in;
  logic [MAX_PATTERN_BYTES-1:0][7:0] cell_out;
  logic [MAX_PATTERN_BYTES-1:0][7:0] cell_pat;
  logic [MAX_PATTERN_BYTES-1:0]      cell_care;
  logic [MAX_PATTERN_BYTES-1:0]      cell_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '1;
      len_q      <= LenRegW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPatLow:  pat_low_q  <= cfg_data_i;
        RegPatHigh: pat_high_q <= cfg_data_i;
        RegMask:    mask_q     <= cfg_data_i[MaskRegW-1:0];
        RegLength:  len_q      <= cfg_data_i[LenRegW-1:0];
        default:    ;
      endcase
    end
  end

  // Length in use: zero counts as one, anything above the window saturates.
  always_comb begin
    len_used = len_q;
    if (len_q == '0) begin
      len_used = LenRegW'(1);
    end else if (len_q > LenRegW'(MAX_PATTERN_BYTES)) begin
      len_used = LenRegW'(MAX_PATTERN_BYTES);
    end
  end

  assign pat_all = {pat_high_q, pat_low_q};

  // Cell i compares the byte i places back, which lines up with pattern byte
  // length-1-i. Cells beyond the pattern length do not take part.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN_BYTES; gi++) begin : g_cell
      logic [3:0] pat_sel;
      assign pat_sel       = 4'(len_used - LenRegW'(1) - LenRegW'(gi));
      assign cell_pat[gi]  = pat_all[pat_sel];
      assign cell_care[gi] = (LenRegW'(gi) < len_used) && mask_q[pat_sel];

      if (gi == 0) begin : g_head
        assign cell_in[gi] = data_byte_i;
      end else begin : g_link
        assign cell_in[gi] = cell_out[gi-1];
      end

      mbps_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .step_i  (accept),
        .clear_i (region_end_i),
        .byte_i  (cell_in[gi]),
        .pat_i   (cell_pat[gi]),
        .care_i  (cell_care[gi]),
        .byte_o  (cell_out[gi]),
        .hit_o   (cell_hit[gi])
      );
    end
  endgenerate

  assign window_hit = &cell_hit;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // The byte count saturates rather than wrapping.
  assign count_nxt   = (count_q == '1) ? count_q : count_q + IndexW'(1);
  assign len_reached = count_nxt >= IndexW'(len_used);

  assign new_found = accept && !reported_q && len_reached && window_hit;
  assign new_miss  = accept && region_end_i && !reported_q && !new_found;

  always_comb begin
    res.found       = new_found;
    res.match_index = new_found ? (count_nxt - IndexW'(len_used)) : '0;
  end

  always_comb begin
    count_d    = count_q;
    reported_d = reported_q;
    if (accept) begin
      count_d    = region_end_i ? '0 : count_nxt;
      reported_d = region_end_i ? 1'b0 : (reported_q || new_found);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      reported_q <= reported_d;
    end
  end

  mbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (new_found || new_miss),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign found_o       = res_out.found;
  assign match_index_o = res_out.match_index;

endmodule

`default_nettype wire

// ----- design/mbps_cell.sv -----
// One window cell of the scanner: holds one byte of the recent window, passes
// it on to the next cell and compares its incoming byte with a pattern byte.
// Depends on nothing outside this file.
`default_nettype none

module mbps_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       clear_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] pat_i,
  input  wire logic       care_i,
  output logic      [7:0] byte_o,
  output logic            hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // The byte arriving this cycle is the one the window position is judged on.
  assign hit_o = !care_i || (byte_i == pat_i);

  always_comb begin
    byte_d = byte_q;
    if (step_i) begin
      byte_d = clear_i ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- design/mbps_out_buf.sv -----
// Two-entry output buffer (output register plus skid register) for results.
// Depends on mbps_pkg for the result type.
`default_nettype none

module mbps_out_buf
  import mbps_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t res_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = res_i;
        end
      end
    end else if (push_i) begin
      // Output is held: park the new result in the skid register.
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire
